/* src/rvid_pkg.sv */
// ----------------------------------------------------------------------------
// rvid_pkg
// Types and constants shared by the instruction decoder modules.
// ----------------------------------------------------------------------------
package rvid_pkg;

  localparam int unsigned InstrW = 32;
  localparam int unsigned MnemW  = 6;
  localparam int unsigned RegW   = 5;
  localparam int unsigned ImmW   = 21;

  // Major opcodes, instruction bits 6..0
  localparam logic [6:0] OPC_R      = 7'd51;
  localparam logic [6:0] OPC_IALU   = 7'd19;
  localparam logic [6:0] OPC_LOAD   = 7'd3;
  localparam logic [6:0] OPC_JALR   = 7'd103;
  localparam logic [6:0] OPC_SYS    = 7'd115;
  localparam logic [6:0] OPC_STORE  = 7'd35;
  localparam logic [6:0] OPC_BRANCH = 7'd99;
  localparam logic [6:0] OPC_JAL    = 7'd111;
  localparam logic [6:0] OPC_AUIPC  = 7'd23;
  localparam logic [6:0] OPC_LUI    = 7'd55;

  localparam logic [6:0] F7_BASE = 7'd0;
  localparam logic [6:0] F7_ALT  = 7'd32;
  localparam logic [5:0] SRAI_HI = 6'd16;

  // Mnemonic numbers
  localparam logic [MnemW-1:0] MN_ADD    = 6'd0;
  localparam logic [MnemW-1:0] MN_XOR    = 6'd1;
  localparam logic [MnemW-1:0] MN_OR     = 6'd2;
  localparam logic [MnemW-1:0] MN_AND    = 6'd3;
  localparam logic [MnemW-1:0] MN_SLL    = 6'd4;
  localparam logic [MnemW-1:0] MN_SRL    = 6'd5;
  localparam logic [MnemW-1:0] MN_SLT    = 6'd6;
  localparam logic [MnemW-1:0] MN_SLTU   = 6'd7;
  localparam logic [MnemW-1:0] MN_SUB    = 6'd8;
  localparam logic [MnemW-1:0] MN_SRA    = 6'd9;
  localparam logic [MnemW-1:0] MN_ADDI   = 6'd10;
  localparam logic [MnemW-1:0] MN_XORI   = 6'd11;
  localparam logic [MnemW-1:0] MN_ORI    = 6'd12;
  localparam logic [MnemW-1:0] MN_ANDI   = 6'd13;
  localparam logic [MnemW-1:0] MN_SLTIU  = 6'd14;
  localparam logic [MnemW-1:0] MN_SLLI   = 6'd15;
  localparam logic [MnemW-1:0] MN_SRLI   = 6'd16;
  localparam logic [MnemW-1:0] MN_SRAI   = 6'd17;
  localparam logic [MnemW-1:0] MN_SLTI   = 6'd18;
  localparam logic [MnemW-1:0] MN_LB     = 6'd19;
  localparam logic [MnemW-1:0] MN_JALR   = 6'd26;
  localparam logic [MnemW-1:0] MN_ECALL  = 6'd27;
  localparam logic [MnemW-1:0] MN_EBREAK = 6'd28;
  localparam logic [MnemW-1:0] MN_SB     = 6'd29;
  localparam logic [MnemW-1:0] MN_BEQ    = 6'd33;
  localparam logic [MnemW-1:0] MN_BNE    = 6'd34;
  localparam logic [MnemW-1:0] MN_BLT    = 6'd35;
  localparam logic [MnemW-1:0] MN_BGE    = 6'd36;
  localparam logic [MnemW-1:0] MN_BLTU   = 6'd37;
  localparam logic [MnemW-1:0] MN_BGEU   = 6'd38;
  localparam logic [MnemW-1:0] MN_JAL    = 6'd39;
  localparam logic [MnemW-1:0] MN_AUIPC  = 6'd40;
  localparam logic [MnemW-1:0] MN_LUI    = 6'd41;
  localparam logic [MnemW-1:0] MN_LAST   = MN_LUI;

  typedef enum logic [2:0] {
    FMT_R = 3'd0,
    FMT_I = 3'd1,
    FMT_S = 3'd2,
    FMT_B = 3'd3,
    FMT_J = 3'd4,
    FMT_U = 3'd5
  } format_e;

  typedef struct packed {
    logic                   valid_res;
    logic signed [ImmW-1:0] immediate;
    logic [RegW-1:0]        src2_reg;
    logic [RegW-1:0]        src1_reg;
    logic [RegW-1:0]        dest_reg;
    format_e                format_kind;
    logic [MnemW-1:0]       mnemonic;
  } dec_res_t;

endpackage

/* src/rvid_decode.sv */
// ----------------------------------------------------------------------------
// rvid_decode
// Field extraction, immediate assembly and legality check of one word.
// ----------------------------------------------------------------------------
module rvid_decode (
  input  logic [rvid_pkg::InstrW-1:0] instr_i,
  output rvid_pkg::dec_res_t          res_o
);

  logic [6:0]                      opc;
  logic [2:0]                      f3;
  logic [6:0]                      f7;
  logic [5:0]                      hi6;
  logic [11:0]                     imm12;
  logic signed [rvid_pkg::ImmW-1:0] imm_i_sx;
  logic                            legal;
  rvid_pkg::dec_res_t              raw;

  assign opc      = instr_i[6:0];
  assign f3       = instr_i[14:12];
  assign f7       = instr_i[31:25];
  assign hi6      = instr_i[31:26];
  assign imm12    = instr_i[31:20];
  assign imm_i_sx = {{(rvid_pkg::ImmW-12){imm12[11]}}, imm12};

  always_comb begin
    raw           = '0;
    raw.valid_res = 1'b1;
    legal         = 1'b1;
    case (opc)
      rvid_pkg::OPC_R: begin
        raw.format_kind = rvid_pkg::FMT_R;
        raw.dest_reg    = instr_i[11:7];
        raw.src1_reg    = instr_i[19:15];
        raw.src2_reg    = instr_i[24:20];
        if (f7 == rvid_pkg::F7_BASE) begin
          case (f3)
            3'd0:    raw.mnemonic = rvid_pkg::MN_ADD;
            3'd1:    raw.mnemonic = rvid_pkg::MN_SLL;
            3'd2:    raw.mnemonic = rvid_pkg::MN_SLT;
            3'd3:    raw.mnemonic = rvid_pkg::MN_SLTU;
            3'd4:    raw.mnemonic = rvid_pkg::MN_XOR;
            3'd5:    raw.mnemonic = rvid_pkg::MN_SRL;
            3'd6:    raw.mnemonic = rvid_pkg::MN_OR;
            default: raw.mnemonic = rvid_pkg::MN_AND;
          endcase
        end else if (f7 == rvid_pkg::F7_ALT && f3 == 3'd0) begin
          raw.mnemonic = rvid_pkg::MN_SUB;
        end else if (f7 == rvid_pkg::F7_ALT && f3 == 3'd5) begin
          raw.mnemonic = rvid_pkg::MN_SRA;
        end else begin
          legal = 1'b0;
        end
      end
      rvid_pkg::OPC_IALU: begin
        raw.format_kind = rvid_pkg::FMT_I;
        raw.dest_reg    = instr_i[11:7];
        raw.src1_reg    = instr_i[19:15];
        raw.immediate   = imm_i_sx;
        case (f3)
          3'd0: raw.mnemonic = rvid_pkg::MN_ADDI;
          3'd2: raw.mnemonic = rvid_pkg::MN_SLTI;
          3'd3: begin
            raw.mnemonic  = rvid_pkg::MN_SLTIU;
            raw.immediate = {{(rvid_pkg::ImmW-12){1'b0}}, imm12};
          end
          3'd4: raw.mnemonic = rvid_pkg::MN_XORI;
          3'd6: raw.mnemonic = rvid_pkg::MN_ORI;
          3'd7: raw.mnemonic = rvid_pkg::MN_ANDI;
          3'd1: begin
            raw.immediate = {{(rvid_pkg::ImmW-6){1'b0}}, instr_i[25:20]};
            raw.mnemonic  = rvid_pkg::MN_SLLI;
            legal         = (hi6 == 6'd0);
          end
          default: begin
            // shift right: logical or arithmetic by the upper six bits
            raw.immediate = {{(rvid_pkg::ImmW-6){1'b0}}, instr_i[25:20]};
            if (hi6 == 6'd0) begin
              raw.mnemonic = rvid_pkg::MN_SRLI;
            end else if (hi6 == rvid_pkg::SRAI_HI) begin
              raw.mnemonic = rvid_pkg::MN_SRAI;
            end else begin
              legal = 1'b0;
            end
          end
        endcase
      end
      rvid_pkg::OPC_LOAD: begin
        raw.format_kind = rvid_pkg::FMT_I;
        raw.dest_reg    = instr_i[11:7];
        raw.src1_reg    = instr_i[19:15];
        raw.immediate   = imm_i_sx;
        raw.mnemonic    = rvid_pkg::MN_LB + {3'd0, f3};
        legal           = (f3 != 3'd7);
      end
      rvid_pkg::OPC_JALR: begin
        raw.format_kind = rvid_pkg::FMT_I;
        raw.dest_reg    = instr_i[11:7];
        raw.src1_reg    = instr_i[19:15];
        raw.immediate   = imm_i_sx;
        raw.mnemonic    = rvid_pkg::MN_JALR;
        legal           = (f3 == 3'd0);
      end
      rvid_pkg::OPC_SYS: begin
        raw.format_kind = rvid_pkg::FMT_I;
        raw.immediate   = imm_i_sx;
        if (f3 == 3'd0 && imm12 == 12'd0) begin
          raw.mnemonic = rvid_pkg::MN_ECALL;
        end else if (f3 == 3'd0 && imm12 == 12'd1) begin
          raw.mnemonic = rvid_pkg::MN_EBREAK;
        end else begin
          legal = 1'b0;
        end
      end
      rvid_pkg::OPC_STORE: begin
        raw.format_kind = rvid_pkg::FMT_S;
        raw.src1_reg    = instr_i[19:15];
        raw.src2_reg    = instr_i[24:20];
        raw.immediate   = {{(rvid_pkg::ImmW-12){instr_i[31]}}, instr_i[31:25], instr_i[11:7]};
        raw.mnemonic    = rvid_pkg::MN_SB + {4'd0, f3[1:0]};
        legal           = !f3[2];
      end
      rvid_pkg::OPC_BRANCH: begin
        raw.format_kind = rvid_pkg::FMT_B;
        raw.src1_reg    = instr_i[19:15];
        raw.src2_reg    = instr_i[24:20];
        raw.immediate   = {{(rvid_pkg::ImmW-13){instr_i[31]}}, instr_i[31], instr_i[7],
                           instr_i[30:25], instr_i[11:8], 1'b0};
        case (f3)
          3'd0:    raw.mnemonic = rvid_pkg::MN_BEQ;
          3'd1:    raw.mnemonic = rvid_pkg::MN_BNE;
          3'd4:    raw.mnemonic = rvid_pkg::MN_BLT;
          3'd5:    raw.mnemonic = rvid_pkg::MN_BGE;
          3'd6:    raw.mnemonic = rvid_pkg::MN_BLTU;
          3'd7:    raw.mnemonic = rvid_pkg::MN_BGEU;
          default: legal = 1'b0;
        endcase
      end
      rvid_pkg::OPC_JAL: begin
        raw.format_kind = rvid_pkg::FMT_J;
        raw.dest_reg    = instr_i[11:7];
        raw.immediate   = {instr_i[31], instr_i[19:12], instr_i[20], instr_i[30:21], 1'b0};
        raw.mnemonic    = rvid_pkg::MN_JAL;
      end
      rvid_pkg::OPC_AUIPC, rvid_pkg::OPC_LUI: begin
        raw.format_kind = rvid_pkg::FMT_U;
        raw.dest_reg    = instr_i[11:7];
        raw.immediate   = {1'b0, instr_i[31:12]};
        raw.mnemonic    = (opc == rvid_pkg::OPC_AUIPC) ? rvid_pkg::MN_AUIPC
                                                       : rvid_pkg::MN_LUI;
      end
      default: legal = 1'b0;
    endcase
  end

  // Zero every field of an unrecognized encoding
  assign res_o = legal ? raw : '0;

endmodule

/* src/riscv_instruction_decoder.sv */
// ----------------------------------------------------------------------------
// riscv_instruction_decoder
// Decodes one 32-bit instruction word per request into operation number,
// format, register fields, immediate and a recognized flag.
//
//   Channel   Dir  Payload (low bit up)
//   s_axis    in   tdata[31:0] instr_word
//   m_axis    out  tdata: mnemonic, format_kind, dest_reg, src1_reg,
//                  src2_reg, immediate (45 bits, zero padded to 48);
//                  tuser: valid_res
//
// One request per cycle sustained while the output is not stalled: an input
// register, then the decode logic, then the result register. Each stage
// advances when the stage after it is empty or draining, so a stalled output
// holds the result register, and the input register too once it is full.
// Reset empties both stages.
// ----------------------------------------------------------------------------
module riscv_instruction_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [31:0] instr_word
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [5:0] mnemonic, [8:6] format_kind, [13:9] dest_reg, [18:14] src1_reg,
  // [23:19] src2_reg, [44:24] immediate, [47:45] zero
  output logic [47:0] m_axis_tdata_o,
  output logic [0:0]  m_axis_tuser_o    // [0] valid_res
);

  logic                          in_vld_q;
  logic [rvid_pkg::InstrW-1:0]   instr_q;
  logic                          out_vld_q;
  rvid_pkg::dec_res_t            res_d, res_q;
  logic                          out_adv;
  logic                          in_adv;

  assign out_adv = !out_vld_q || m_axis_tready_i;
  assign in_adv  = !in_vld_q || out_adv;

  assign s_axis_tready_o = in_adv;

  rvid_decode u_decode (
    .instr_i (instr_q),
    .res_o   (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_adv) begin
        in_vld_q <= s_axis_tvalid_i;
      end
      if (out_adv) begin
        out_vld_q <= in_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_adv && s_axis_tvalid_i) begin
      instr_q <= s_axis_tdata_i;
    end
    if (out_adv && in_vld_q) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {3'b000, res_q.immediate, res_q.src2_reg, res_q.src1_reg,
                            res_q.dest_reg, res_q.format_kind, res_q.mnemonic};
  assign m_axis_tuser_o  = res_q.valid_res;

endmodule

/* src/rvid_checker.sv */
// ----------------------------------------------------------------------------
// rvid_checker
// Port-level checks of the instruction decoder, bound to the top level.
// ----------------------------------------------------------------------------
module rvid_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic [31:0] s_axis_tdata_i,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [47:0] m_axis_tdata_o,
  input logic [0:0]  m_axis_tuser_o
);

  logic s_acc;

  assign s_acc = s_axis_tvalid_i && s_axis_tready_o;

  // Hold a waiting request
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && !s_axis_tready_o |=> s_axis_tvalid_i && $stable(s_axis_tdata_i))
    else $error("waiting request changed");

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o)
      && $stable(m_axis_tuser_o))
    else $error("stalled result changed");

  // An unrecognized word reports all fields as zero
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o[0] |-> m_axis_tdata_o == 48'd0)
    else $error("invalid result carries nonzero fields");

  // A recognized word gives a defined operation and format
  a_codes_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[0] |->
      m_axis_tdata_o[5:0] <= rvid_pkg::MN_LAST
      && m_axis_tdata_o[8:6] <= 3'(rvid_pkg::FMT_U) && m_axis_tdata_o[47:45] == 3'd0)
    else $error("result code out of range");

  // An accepted request reaches the output register when the output drains
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc ##1 m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("request did not reach the output");

endmodule

bind riscv_instruction_decoder rvid_checker u_rvid_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tdata_i  (s_axis_tdata_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

/* test/tb_riscv_instruction_decoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_riscv_instruction_decoder
// Self-checking bench for the instruction decoder. Instruction words go in
// through the input stream: first a handful of hand-picked encodings, then
// mostly legal random instructions mixed with noise. A scoreboard decodes
// every accepted word on its own and compares each returned result field by
// field. The sender idles in random bursts and the receiver stalls in
// changing patterns.
// ----------------------------------------------------------------------------
module tb_riscv_instruction_decoder;

  localparam int unsigned NumRandom = 1600;
  localparam int unsigned IdleLimit = 2000;

  // funct3 codes, shared between R and I-alu where the encodings line up
  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SLT  = 3'd2;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SR   = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;
  localparam logic [2:0] F3_PRIV = 3'd0;
  localparam logic [2:0] F3_SD   = 3'd3;
  localparam logic [2:0] F3_NO_LOAD = 3'd7;
  localparam logic [2:0] F3_BEQ  = 3'd0;
  localparam logic [2:0] F3_BNE  = 3'd1;
  localparam logic [2:0] F3_BLT  = 3'd4;
  localparam logic [2:0] F3_BGE  = 3'd5;
  localparam logic [2:0] F3_BLTU = 3'd6;
  localparam logic [2:0] F3_BGEU = 3'd7;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_PERIODIC,
    RX_SPARSE
  } rx_mode_e;

  typedef struct {
    logic [31:0]        word;
    rvid_pkg::dec_res_t res;
  } pending_t;

  class dec_scoreboard;
    pending_t    pending_q[$];
    int unsigned mismatches = 0;

    function rvid_pkg::dec_res_t decode_word(logic [31:0] w);
      rvid_pkg::dec_res_t r;
      logic [20:0]        imm_i;
      logic               ok;
      r     = '0;
      ok    = 1'b1;
      imm_i = {{9{w[31]}}, w[31:20]};
      case (w[6:0])
        rvid_pkg::OPC_R: begin
          r.format_kind = rvid_pkg::FMT_R;
          r.dest_reg    = w[11:7];
          r.src1_reg    = w[19:15];
          r.src2_reg    = w[24:20];
          if (w[31:25] == rvid_pkg::F7_BASE) begin
            case (w[14:12])
              F3_ADD:  r.mnemonic = rvid_pkg::MN_ADD;
              F3_SLL:  r.mnemonic = rvid_pkg::MN_SLL;
              F3_SLT:  r.mnemonic = rvid_pkg::MN_SLT;
              F3_SLTU: r.mnemonic = rvid_pkg::MN_SLTU;
              F3_XOR:  r.mnemonic = rvid_pkg::MN_XOR;
              F3_SR:   r.mnemonic = rvid_pkg::MN_SRL;
              F3_OR:   r.mnemonic = rvid_pkg::MN_OR;
              default: r.mnemonic = rvid_pkg::MN_AND;
            endcase
          end else if (w[31:25] == rvid_pkg::F7_ALT && w[14:12] == F3_ADD) begin
            r.mnemonic = rvid_pkg::MN_SUB;
          end else if (w[31:25] == rvid_pkg::F7_ALT && w[14:12] == F3_SR) begin
            r.mnemonic = rvid_pkg::MN_SRA;
          end else begin
            ok = 1'b0;
          end
        end
        rvid_pkg::OPC_IALU: begin
          r.format_kind = rvid_pkg::FMT_I;
          r.dest_reg    = w[11:7];
          r.src1_reg    = w[19:15];
          r.immediate   = imm_i;
          case (w[14:12])
            F3_ADD:  r.mnemonic = rvid_pkg::MN_ADDI;
            F3_SLT:  r.mnemonic = rvid_pkg::MN_SLTI;
            F3_XOR:  r.mnemonic = rvid_pkg::MN_XORI;
            F3_OR:   r.mnemonic = rvid_pkg::MN_ORI;
            F3_AND:  r.mnemonic = rvid_pkg::MN_ANDI;
            F3_SLTU: begin
              r.mnemonic  = rvid_pkg::MN_SLTIU;
              r.immediate = {9'd0, w[31:20]};
            end
            F3_SLL: begin
              r.immediate = {15'd0, w[25:20]};
              r.mnemonic  = rvid_pkg::MN_SLLI;
              ok          = (w[31:26] == 6'd0);
            end
            default: begin
              r.immediate = {15'd0, w[25:20]};
              if (w[31:26] == 6'd0) begin
                r.mnemonic = rvid_pkg::MN_SRLI;
              end else if (w[31:26] == rvid_pkg::SRAI_HI) begin
                r.mnemonic = rvid_pkg::MN_SRAI;
              end else begin
                ok = 1'b0;
              end
            end
          endcase
        end
        rvid_pkg::OPC_LOAD: begin
          r.format_kind = rvid_pkg::FMT_I;
          r.dest_reg    = w[11:7];
          r.src1_reg    = w[19:15];
          r.immediate   = imm_i;
          r.mnemonic    = rvid_pkg::MN_LB + {3'd0, w[14:12]};
          ok            = (w[14:12] != F3_NO_LOAD);
        end
        rvid_pkg::OPC_JALR: begin
          r.format_kind = rvid_pkg::FMT_I;
          r.dest_reg    = w[11:7];
          r.src1_reg    = w[19:15];
          r.immediate   = imm_i;
          r.mnemonic    = rvid_pkg::MN_JALR;
          ok            = (w[14:12] == F3_PRIV);
        end
        rvid_pkg::OPC_SYS: begin
          // register fields are not reported for ecall / ebreak
          r.format_kind = rvid_pkg::FMT_I;
          r.immediate   = imm_i;
          if (w[14:12] == F3_PRIV && imm_i == 21'd0) begin
            r.mnemonic = rvid_pkg::MN_ECALL;
          end else if (w[14:12] == F3_PRIV && imm_i == 21'd1) begin
            r.mnemonic = rvid_pkg::MN_EBREAK;
          end else begin
            ok = 1'b0;
          end
        end
        rvid_pkg::OPC_STORE: begin
          r.format_kind = rvid_pkg::FMT_S;
          r.src1_reg    = w[19:15];
          r.src2_reg    = w[24:20];
          r.immediate   = {{9{w[31]}}, w[31:25], w[11:7]};
          r.mnemonic    = rvid_pkg::MN_SB + {3'd0, w[14:12]};
          ok            = (w[14:12] <= F3_SD);
        end
        rvid_pkg::OPC_BRANCH: begin
          r.format_kind = rvid_pkg::FMT_B;
          r.src1_reg    = w[19:15];
          r.src2_reg    = w[24:20];
          r.immediate   = {{8{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
          case (w[14:12])
            F3_BEQ:  r.mnemonic = rvid_pkg::MN_BEQ;
            F3_BNE:  r.mnemonic = rvid_pkg::MN_BNE;
            F3_BLT:  r.mnemonic = rvid_pkg::MN_BLT;
            F3_BGE:  r.mnemonic = rvid_pkg::MN_BGE;
            F3_BLTU: r.mnemonic = rvid_pkg::MN_BLTU;
            F3_BGEU: r.mnemonic = rvid_pkg::MN_BGEU;
            default: ok = 1'b0;
          endcase
        end
        rvid_pkg::OPC_JAL: begin
          r.format_kind = rvid_pkg::FMT_J;
          r.dest_reg    = w[11:7];
          r.immediate   = {w[31], w[19:12], w[20], w[30:21], 1'b0};
          r.mnemonic    = rvid_pkg::MN_JAL;
        end
        rvid_pkg::OPC_AUIPC, rvid_pkg::OPC_LUI: begin
          r.format_kind = rvid_pkg::FMT_U;
          r.dest_reg    = w[11:7];
          r.immediate   = {1'b0, w[31:12]};
          r.mnemonic    = (w[6:0] == rvid_pkg::OPC_AUIPC) ? rvid_pkg::MN_AUIPC
                                                          : rvid_pkg::MN_LUI;
        end
        default: ok = 1'b0;
      endcase
      if (!ok) begin
        r = '0;
      end else begin
        r.valid_res = 1'b1;
      end
      return r;
    endfunction

    function string show(rvid_pkg::dec_res_t r);
      return $sformatf("mn=%0d fmt=%0d rd=%0d rs1=%0d rs2=%0d imm=%0d ok=%0b",
                       r.mnemonic, r.format_kind, r.dest_reg, r.src1_reg,
                       r.src2_reg, r.immediate, r.valid_res);
    endfunction

    function void note_instr(logic [31:0] w);
      pending_t p;
      p.word = w;
      p.res  = decode_word(w);
      pending_q.push_back(p);
    endfunction

    function void check_result(logic [47:0] data, logic [0:0] user);
      rvid_pkg::dec_res_t got;
      pending_t           want;
      got.mnemonic    = data[5:0];
      got.format_kind = rvid_pkg::format_e'(data[8:6]);
      got.dest_reg    = data[13:9];
      got.src1_reg    = data[18:14];
      got.src2_reg    = data[23:19];
      got.immediate   = data[44:24];
      got.valid_res   = user[0];
      if (pending_q.size() == 0) begin
        if (mismatches < 10) $display("unexpected result: %s", show(got));
        mismatches++;
        return;
      end
      want = pending_q.pop_front();
      if (got.mnemonic !== want.res.mnemonic || got.format_kind !== want.res.format_kind ||
          got.dest_reg !== want.res.dest_reg || got.src1_reg !== want.res.src1_reg ||
          got.src2_reg !== want.res.src2_reg || got.immediate !== want.res.immediate ||
          got.valid_res !== want.res.valid_res || data[47:45] !== 3'b000) begin
        if (mismatches < 10) begin
          $display("mismatch on %08h (pad %03b)", want.word, data[47:45]);
          $display("  expected %s", show(want.res));
          $display("  actual   %s", show(got));
        end
        mismatches++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [31:0] s_axis_tdata_i = '0;   // [31:0] instr_word
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  // [5:0] mnemonic, [8:6] format_kind, [13:9] dest_reg, [18:14] src1_reg,
  // [23:19] src2_reg, [44:24] immediate, [47:45] zero
  logic [47:0] m_axis_tdata_o;
  logic [0:0]  m_axis_tuser_o;        // [0] valid_res

  dec_scoreboard sb = new();
  int unsigned   burst_left = 0;
  int unsigned   idle_cycles = 0;
  int unsigned   rx_left = 0;
  int unsigned   rx_phase = 0;
  rx_mode_e      rx_mode = RX_OPEN;

  riscv_instruction_decoder dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic logic [31:0] enc(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
                                      logic [2:0] f3, logic [4:0] rd, logic [6:0] opc);
    return {f7, rs2, rs1, f3, rd, opc};
  endfunction

  // Present one request and hold it until accepted; sometimes open a gap between bursts.
  task automatic send_instr(input logic [31:0] w);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
      if (gap != 0) begin
        s_axis_tvalid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= w;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    burst_left--;
  endtask

  // Receiver backpressure: switch between a few stall patterns.
  always @(posedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_left = $urandom_range(50, 300);
    end
    rx_left--;
    rx_phase++;
    case (rx_mode)
      RX_OPEN:     m_axis_tready_i <= 1'b1;
      RX_COIN:     m_axis_tready_i <= 1'($urandom_range(0, 1));
      RX_PERIODIC: m_axis_tready_i <= (rx_phase % 3 != 0);
      default:     m_axis_tready_i <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // Monitor both sides and watch for a hang.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) sb.note_instr(s_axis_tdata_i);
      if (m_axis_tvalid_o && m_axis_tready_i) sb.check_result(m_axis_tdata_o, m_axis_tuser_o);
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("timeout: no transfer for %0d cycles", IdleLimit);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    logic [31:0] w;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_instr(32'h0000_0000);
    send_instr(32'hFFFF_FFFF);
    send_instr(enc(rvid_pkg::F7_BASE, 5'd31, 5'd31, F3_ADD, 5'd31, rvid_pkg::OPC_R));
    send_instr(enc(rvid_pkg::F7_ALT, 5'd1, 5'd2, F3_ADD, 5'd3, rvid_pkg::OPC_R));
    send_instr(enc(rvid_pkg::F7_ALT, 5'd5, 5'd6, F3_SR, 5'd7, rvid_pkg::OPC_R));
    // bad funct3 under alt
    send_instr(enc(rvid_pkg::F7_ALT, 5'd1, 5'd1, F3_SLL, 5'd1, rvid_pkg::OPC_R));
    send_instr(enc(7'd1, 5'd1, 5'd1, F3_ADD, 5'd1, rvid_pkg::OPC_R));        // bad funct7
    send_instr(enc(7'h7F, 5'h1F, 5'd0, F3_ADD, 5'd1, rvid_pkg::OPC_IALU));
    // sltiu stays unsigned
    send_instr(enc(7'h7F, 5'h1F, 5'd3, F3_SLTU, 5'd4, rvid_pkg::OPC_IALU));
    send_instr(enc(7'h01, 5'h1F, 5'd2, F3_SLL, 5'd2, rvid_pkg::OPC_IALU));   // shamt 63
    send_instr(enc(7'h20, 5'd3, 5'd2, F3_SR, 5'd2, rvid_pkg::OPC_IALU));
    // bad shift high bits
    send_instr(enc(7'h02, 5'd0, 5'd2, F3_SR, 5'd2, rvid_pkg::OPC_IALU));
    send_instr(enc(7'h20, 5'd0, 5'd2, F3_SLL, 5'd2, rvid_pkg::OPC_IALU));
    send_instr(enc(7'h40, 5'd0, 5'd5, F3_SD, 5'd6, rvid_pkg::OPC_LOAD));
    send_instr(enc(7'd0, 5'd0, 5'd5, F3_NO_LOAD, 5'd6, rvid_pkg::OPC_LOAD));
    send_instr(enc(7'h3F, 5'h1F, 5'd1, F3_PRIV, 5'd1, rvid_pkg::OPC_JALR));
    send_instr(enc(7'd0, 5'd0, 5'd1, F3_NO_LOAD, 5'd1, rvid_pkg::OPC_JALR));
    send_instr(enc(7'd0, 5'd0, 5'd9, F3_PRIV, 5'd9, rvid_pkg::OPC_SYS));     // ecall, junk regs
    send_instr(enc(7'd0, 5'd1, 5'd0, F3_PRIV, 5'd0, rvid_pkg::OPC_SYS));
    send_instr(enc(7'd0, 5'd2, 5'd0, F3_PRIV, 5'd0, rvid_pkg::OPC_SYS));
    send_instr(enc(7'd0, 5'd0, 5'd0, F3_NO_LOAD, 5'd0, rvid_pkg::OPC_SYS));
    send_instr(enc(7'h7F, 5'd31, 5'd31, F3_SD, 5'd31, rvid_pkg::OPC_STORE));
    send_instr(enc(7'd0, 5'd1, 5'd1, F3_XOR, 5'd1, rvid_pkg::OPC_STORE));
    send_instr(enc(7'h7F, 5'd31, 5'd31, F3_BGEU, 5'd31, rvid_pkg::OPC_BRANCH));
    send_instr(enc(7'h40, 5'd1, 5'd1, F3_SLT, 5'd0, rvid_pkg::OPC_BRANCH));
    send_instr({20'hFFFFF, 5'd1, rvid_pkg::OPC_JAL});
    send_instr({20'h80000, 5'd0, rvid_pkg::OPC_AUIPC});
    send_instr({20'hFFFFF, 5'd31, rvid_pkg::OPC_LUI});

    repeat (NumRandom) begin
      w = $urandom();
      // mostly legal major opcodes, the rest left as noise
      if ($urandom_range(0, 99) < 88) begin
        case ($urandom_range(0, 9))
          0:       w[6:0] = rvid_pkg::OPC_R;
          1:       w[6:0] = rvid_pkg::OPC_IALU;
          2:       w[6:0] = rvid_pkg::OPC_LOAD;
          3:       w[6:0] = rvid_pkg::OPC_JALR;
          4:       w[6:0] = rvid_pkg::OPC_SYS;
          5:       w[6:0] = rvid_pkg::OPC_STORE;
          6:       w[6:0] = rvid_pkg::OPC_BRANCH;
          7:       w[6:0] = rvid_pkg::OPC_JAL;
          8:       w[6:0] = rvid_pkg::OPC_AUIPC;
          default: w[6:0] = rvid_pkg::OPC_LUI;
        endcase
      end
      // steer sparse fields toward legal values most of the time
      if (w[6:0] == rvid_pkg::OPC_R && $urandom_range(0, 9) < 8) begin
        w[31:25] = $urandom_range(0, 1) ? rvid_pkg::F7_ALT : rvid_pkg::F7_BASE;
      end
      if (w[6:0] == rvid_pkg::OPC_IALU && (w[14:12] == F3_SLL || w[14:12] == F3_SR) &&
          $urandom_range(0, 9) < 7) begin
        w[31:26] = $urandom_range(0, 1) ? rvid_pkg::SRAI_HI : 6'd0;
      end
      if (w[6:0] == rvid_pkg::OPC_SYS && $urandom_range(0, 9) < 7) begin
        w[14:12] = F3_PRIV;
        w[31:20] = {11'd0, 1'($urandom_range(0, 1))};
      end
      send_instr(w);
    end
    s_axis_tvalid_i <= 1'b0;

    // let the monitor log the last accepted request first
    @(posedge clk_i);
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* riscv_instruction_decoder.f */
src/rvid_pkg.sv
src/rvid_decode.sv
src/riscv_instruction_decoder.sv
src/rvid_checker.sv
test/tb_riscv_instruction_decoder.sv
